@@ design/cpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Capture period meter package
// Shared constants, status and command codes, and the snapshot record that
// passes from the state tracker to the output scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int RES_W          = 32;
    localparam int TICK_W         = 7;
    localparam int TMO_W          = 16;
    localparam int THR_W          = 26;
    localparam int WRAP_BITS      = 16;
    localparam int US_PER_MS      = 1000;
    localparam int TIMEOUT_RESET  = 500;
    localparam int TICK_RESET     = 4;
    localparam int CFG_IDX_W      = 1;

    localparam logic [THR_W-1:0]  THR_RESET     = THR_W'(TIMEOUT_RESET * US_PER_MS);
    localparam logic [TICK_W-1:0] TICK_US_RESET = TICK_W'(TICK_RESET);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_ARMED    = 3'd1,
        ST_COUNTING = 3'd2,
        ST_DONE     = 3'd3,
        ST_TIMEOUT  = 3'd4
    } status_code_t;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CAPTURE = 2'd1,
        CMD_SET     = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_MS = 1'b0,
        REG_TICK_US    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        status_code_t     status;
        logic             timed_out;
        logic [RES_W-1:0] start_ticks;
        logic [RES_W-1:0] period_ticks;
        logic [RES_W-1:0] elapsed_ticks;
    } snap_t;

endpackage

`default_nettype wire

@@ design/cpm_tracker.sv @@
// ----------------------------------------------------------------------------
// Capture period meter state tracker
// Applies one command per transfer to the time count, stamps and status, and
// registers a snapshot of the updated state in tick units.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_tracker import cpm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [2:0]        new_status,
    input  wire logic [TICK_W-1:0] tick_us,
    input  wire logic [THR_W-1:0]  threshold,
    output logic                   snap_valid,
    input  wire logic              snap_ready,
    output snap_t                  snap
);

    localparam int EXT_W = (TIME_WIDTH > RES_W) ? TIME_WIDTH : RES_W;

    logic [TIME_WIDTH-1:0] count_reg, count_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [TIME_WIDTH-1:0] stop_reg, stop_next;
    logic [TIME_WIDTH-1:0] diff_reg, diff_next;
    status_code_t          status_reg, status_next;
    logic                  flag_reg, flag_next;
    snap_t                 snap_reg, snap_next;
    logic                  snap_valid_reg;

    logic [TIME_WIDTH-1:0]      count_inc;
    logic [TIME_WIDTH-1:0]      diff_inc;
    logic [RES_W+TICK_W-1:0]    probe_prod;
    logic                       wrap_hit;
    logic                       over_limit;
    logic                       accept;

    function automatic logic [RES_W-1:0] to_res(input logic [TIME_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[RES_W-1:0];
    endfunction

    assign in_ready   = !snap_valid_reg || snap_ready;
    assign accept     = in_valid && in_ready;
    assign count_inc  = count_reg + TIME_WIDTH'(1);
    assign diff_inc   = diff_reg + TIME_WIDTH'(1);
    assign probe_prod = {TICK_W'(0), to_res(diff_inc)} * {RES_W'(0), tick_us};
    assign wrap_hit   = (count_inc[WRAP_BITS-1:0] == '0);
    assign over_limit = (probe_prod[RES_W-1:0] >= RES_W'(threshold));

    always_comb begin
        count_next  = count_reg;
        start_next  = start_reg;
        stop_next   = stop_reg;
        diff_next   = diff_reg;
        status_next = status_reg;
        flag_next   = flag_reg;
        case (cmd_t'(command))
            CMD_TICK: begin
                count_next = count_inc;
                diff_next  = diff_inc;
                if (wrap_hit && status_reg == ST_COUNTING && over_limit) begin
                    flag_next   = 1'b1;
                    status_next = ST_TIMEOUT;
                end
            end
            CMD_CAPTURE: begin
                if (status_reg == ST_ARMED) begin
                    start_next  = count_reg;
                    diff_next   = '0;
                    flag_next   = 1'b0;
                    status_next = ST_COUNTING;
                end else if (status_reg == ST_COUNTING) begin
                    stop_next   = count_reg;
                    status_next = ST_DONE;
                end
            end
            CMD_SET: begin
                if (new_status <= ST_TIMEOUT) begin
                    status_next = status_code_t'(new_status);
                end
            end
            default: begin
                count_next  = '0;
                diff_next   = TIME_WIDTH'(0) - start_reg;
                status_next = ST_IDLE;
                flag_next   = 1'b0;
            end
        endcase

        snap_next.status        = status_next;
        snap_next.timed_out     = flag_next;
        snap_next.start_ticks   = to_res(start_next);
        snap_next.period_ticks  = to_res(stop_next - start_next);
        snap_next.elapsed_ticks = to_res(diff_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            start_reg      <= '0;
            stop_reg       <= '0;
            diff_reg       <= '0;
            status_reg     <= ST_IDLE;
            flag_reg       <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= accept || (snap_valid_reg && !snap_ready);
            if (accept) begin
                count_reg  <= count_next;
                start_reg  <= start_next;
                stop_reg   <= stop_next;
                diff_reg   <= diff_next;
                status_reg <= status_next;
                flag_reg   <= flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

@@ design/cpm_scaler.sv @@
// ----------------------------------------------------------------------------
// Capture period meter output scaler
// Converts a snapshot from ticks to microseconds and holds the result until
// the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_scaler import cpm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              snap_valid,
    output logic                   snap_ready,
    input  wire snap_t             snap,
    input  wire logic [TICK_W-1:0] tick_us,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_status,
    output logic                   m_timed_out,
    output logic [RES_W-1:0]       m_start_us,
    output logic [RES_W-1:0]       m_period_us,
    output logic [RES_W-1:0]       m_elapsed_us
);

    logic             m_valid_reg;
    status_code_t     status_reg;
    logic             flag_reg;
    logic [RES_W-1:0] start_us_reg;
    logic [RES_W-1:0] period_us_reg;
    logic [RES_W-1:0] elapsed_us_reg;
    logic             take;

    function automatic logic [RES_W-1:0] scale(input logic [RES_W-1:0] v,
                                               input logic [TICK_W-1:0] t);
        logic [RES_W+TICK_W-1:0] p;
        p = {TICK_W'(0), v} * {RES_W'(0), t};
        return p[RES_W-1:0];
    endfunction

    assign snap_ready = !m_valid_reg || m_ready;
    assign take       = snap_valid && snap_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= take || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg     <= snap.status;
            flag_reg       <= snap.timed_out;
            start_us_reg   <= scale(snap.start_ticks, tick_us);
            period_us_reg  <= scale(snap.period_ticks, tick_us);
            elapsed_us_reg <= scale(snap.elapsed_ticks, tick_us);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_timed_out  = flag_reg;
    assign m_start_us   = start_us_reg;
    assign m_period_us  = period_us_reg;
    assign m_elapsed_us = elapsed_us_reg;

endmodule

`default_nettype wire

@@ design/capture_period_meter_top.sv @@
// ----------------------------------------------------------------------------
// Capture period meter
// Free-running tick counter with capture stamps, status control and a
// timeout check every 65536 ticks; results are reported in microseconds.
//
//   Channel  Direction  Payload
//   s_       in         command, new_status
//   m_       out        status, timed_out, start_us, period_us, elapsed_us
//   cfg_     in         write enable, register index, 16-bit write data
//
// One item is accepted per cycle while s_ready is high; its result passes
// through the state update stage and then the microsecond scaling stage.
// The timeout check and the three tick-to-microsecond conversions each use
// one 32x7 multiplier in their stage.
// Reset clears the count, stamps and status, and empties both stages.
// A stalled result holds the scaling stage; the tracker stage still takes
// one more item before s_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_meter_top import cpm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TMO_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_command,
    input  wire logic [2:0]           s_new_status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_status,
    output logic                      m_timed_out,
    output logic [RES_W-1:0]          m_start_us,
    output logic [RES_W-1:0]          m_period_us,
    output logic [RES_W-1:0]          m_elapsed_us
);

    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [TICK_W-1:0] tick_us_reg;
    logic              snap_valid;
    logic              snap_ready;
    snap_t             snap;

    assign thr_next = THR_W'(32'(cfg_wr_data) * 32'(US_PER_MS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THR_RESET;
            tick_us_reg <= TICK_US_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TIMEOUT_MS: thr_reg     <= thr_next;
                REG_TICK_US:    tick_us_reg <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    cpm_tracker #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .command    (s_command),
        .new_status (s_new_status),
        .tick_us    (tick_us_reg),
        .threshold  (thr_reg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    cpm_scaler u_scaler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .tick_us      (tick_us_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_timed_out  (m_timed_out),
        .m_start_us   (m_start_us),
        .m_period_us  (m_period_us),
        .m_elapsed_us (m_elapsed_us)
    );

endmodule

`default_nettype wire

@@ design/cpm_checker.sv @@
// ----------------------------------------------------------------------------
// Capture period meter port checker
// Watches the top-level ports for reset, buffering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic        m_timed_out,
    input wire logic [31:0] m_start_us,
    input wire logic [31:0] m_period_us,
    input wire logic [31:0] m_elapsed_us
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With no result held, both stages can drain, so input is always taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");

    // A transfer taken while the output stalls fills the tracker stage.
    a_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && $past(m_valid && !m_ready && s_valid && s_ready)
        |-> !s_ready)
        else $error("more than two items buffered");

    // A stalled result keeps its payload.
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_timed_out)
        && $stable(m_start_us) && $stable(m_period_us) && $stable(m_elapsed_us))
        else $error("stalled result changed");

endmodule

bind capture_period_meter_top cpm_checker u_cpm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_timed_out  (m_timed_out),
    .m_start_us   (m_start_us),
    .m_period_us  (m_period_us),
    .m_elapsed_us (m_elapsed_us)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture period meter testbench
// Drives command transfers into the meter and checks every result transfer
// against an in-bench model of the tick count, the capture stamps, the status
// and the timeout check. A short table of hand-checked steps comes first. It
// is followed by random command mixes under three register settings. Both
// channels idle at random, and the result side holds off long enough to stall
// the input.
// ----------------------------------------------------------------------------

module tb;
    import cpm_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PRINT_CAP   = 40;
    localparam int DIR_N       = 24;

    typedef struct packed {
        status_code_t status;
        logic         timed_out;
        logic [31:0]  start_us;
        logic [31:0]  period_us;
        logic [31:0]  elapsed_us;
    } meter_result_t;

    typedef struct packed {
        cmd_t          cmd;
        logic [2:0]    new_status;
        logic          typed;
        meter_result_t want;
    } step_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TMO_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command = '0;
    logic [2:0]           s_new_status = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic                 m_timed_out;
    logic [RES_W-1:0]     m_start_us;
    logic [RES_W-1:0]     m_period_us;
    logic [RES_W-1:0]     m_elapsed_us;

    logic [31:0]  cnt_ticks;
    logic [31:0]  start_ticks;
    logic [31:0]  stop_ticks;
    status_code_t cur_status;
    logic         timeout_flag;
    logic [15:0]  tmo_ms;
    logic [6:0]   tick_us_r;

    meter_result_t expected_readings[$];
    int err_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int timeout_hits = 0;
    int cycle_count = 0;
    int src_idle = 0;
    int sink_idle = 0;
    int hold_left = 0;
    bit hold_pending = 1'b0;

    step_row_t dir_rows [0:DIR_N-1] = '{
        '{CMD_TICK,    3'd5, 1'b1, '{ST_IDLE,     1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_CAPTURE, 3'd0, 1'b1, '{ST_IDLE,     1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_SET,     3'd5, 1'b1, '{ST_IDLE,     1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_SET,     3'd7, 1'b1, '{ST_IDLE,     1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_SET,     3'd6, 1'b1, '{ST_IDLE,     1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_SET,     3'd1, 1'b1, '{ST_ARMED,    1'b0, 32'd0, 32'd0, 32'd4}},
        '{CMD_TICK,    3'd7, 1'b1, '{ST_ARMED,    1'b0, 32'd0, 32'd0, 32'd8}},
        '{CMD_CAPTURE, 3'd2, 1'b1, '{ST_COUNTING, 1'b0, 32'd8, 32'hFFFF_FFF8, 32'd0}},
        '{CMD_TICK,    3'd3, 1'b1, '{ST_COUNTING, 1'b0, 32'd8, 32'hFFFF_FFF8, 32'd4}},
        '{CMD_TICK,    3'd4, 1'b1, '{ST_COUNTING, 1'b0, 32'd8, 32'hFFFF_FFF8, 32'd8}},
        '{CMD_CAPTURE, 3'd1, 1'b1, '{ST_DONE,     1'b0, 32'd8, 32'd8, 32'd8}},
        '{CMD_CAPTURE, 3'd6, 1'b1, '{ST_DONE,     1'b0, 32'd8, 32'd8, 32'd8}},
        '{CMD_SET,     3'd4, 1'b1, '{ST_TIMEOUT,  1'b0, 32'd8, 32'd8, 32'd8}},
        '{CMD_CAPTURE, 3'd3, 1'b1, '{ST_TIMEOUT,  1'b0, 32'd8, 32'd8, 32'd8}},
        '{CMD_SET,     3'd2, 1'b1, '{ST_COUNTING, 1'b0, 32'd8, 32'd8, 32'd8}},
        '{CMD_TICK,    3'd0, 1'b1, '{ST_COUNTING, 1'b0, 32'd8, 32'd8, 32'd12}},
        '{CMD_CAPTURE, 3'd5, 1'b1, '{ST_DONE,     1'b0, 32'd8, 32'd12, 32'd12}},
        '{CMD_RESTART, 3'd7, 1'b1, '{ST_IDLE,     1'b0, 32'd8, 32'd12, 32'hFFFF_FFF8}},
        '{CMD_SET,     3'd3, 1'b1, '{ST_DONE,     1'b0, 32'd8, 32'd12, 32'hFFFF_FFF8}},
        '{CMD_SET,     3'd0, 1'b1, '{ST_IDLE,     1'b0, 32'd8, 32'd12, 32'hFFFF_FFF8}},
        '{CMD_TICK,    3'd2, 1'b0, '0},
        '{CMD_SET,     3'd1, 1'b0, '0},
        '{CMD_CAPTURE, 3'd4, 1'b0, '0},
        '{CMD_RESTART, 3'd0, 1'b1, '{ST_IDLE,     1'b0, 32'd4, 32'd16, 32'hFFFF_FFFC}}
    };

    capture_period_meter_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_new_status (s_new_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_timed_out  (m_timed_out),
        .m_start_us   (m_start_us),
        .m_period_us  (m_period_us),
        .m_elapsed_us (m_elapsed_us)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] to_us(logic [31:0] ticks);
        return ticks * {25'd0, tick_us_r};
    endfunction

    function automatic meter_result_t advance_meter(cmd_t cmd, logic [2:0] ns);
        meter_result_t r;
        case (cmd)
            CMD_TICK: begin
                cnt_ticks = cnt_ticks + 32'd1;
                if (cnt_ticks[WRAP_BITS-1:0] == '0 && cur_status == ST_COUNTING &&
                        to_us(cnt_ticks - start_ticks) / 32'(US_PER_MS) >= {16'd0, tmo_ms}) begin
                    timeout_flag = 1'b1;
                    cur_status = ST_TIMEOUT;
                    timeout_hits++;
                end
            end
            CMD_CAPTURE: begin
                if (cur_status == ST_ARMED) begin
                    start_ticks = cnt_ticks;
                    timeout_flag = 1'b0;
                    cur_status = ST_COUNTING;
                end else if (cur_status == ST_COUNTING) begin
                    stop_ticks = cnt_ticks;
                    cur_status = ST_DONE;
                end
            end
            CMD_SET: begin
                if (ns <= ST_TIMEOUT) begin
                    cur_status = status_code_t'(ns);
                end
            end
            default: begin
                cnt_ticks = '0;
                cur_status = ST_IDLE;
                timeout_flag = 1'b0;
            end
        endcase
        r.status = cur_status;
        r.timed_out = timeout_flag;
        r.start_us = to_us(start_ticks);
        r.period_us = to_us(stop_ticks - start_ticks);
        r.elapsed_us = to_us(cnt_ticks - start_ticks);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %h want %h",
                checked_count, name, got, want));
        end
    endtask

    task automatic check_result();
        meter_result_t want;
        if (expected_readings.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
        end else begin
            want = expected_readings.pop_front();
            check_field("status", 32'(m_status), 32'(want.status));
            check_field("timed_out", 32'(m_timed_out), 32'(want.timed_out));
            check_field("start_us", m_start_us, want.start_us);
            check_field("period_us", m_period_us, want.period_us);
            check_field("elapsed_us", m_elapsed_us, want.elapsed_us);
        end
        checked_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = 64;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                cycle_count, expected_readings.size());
            $display("[capture_period_meter_top] ERROR");
            $finish;
        end
    end

    task automatic send_item(cmd_t cmd, logic [2:0] ns, logic typed, meter_result_t want);
        meter_result_t got;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_new_status <= ns;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        got = advance_meter(cmd, ns);
        expected_readings.push_back(typed ? want : got);
        sent_count++;
    endtask

    task automatic finish_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_regs(logic [15:0] timeout_val, logic [6:0] tick_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TIMEOUT_MS;
        cfg_wr_data <= timeout_val;
        @(posedge aclk);
        cfg_index <= REG_TICK_US;
        cfg_wr_data <= {9'd0, tick_val};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tmo_ms = timeout_val;
        tick_us_r = tick_val;
    endtask

    task automatic random_items(int n, bit with_hold);
        int r;
        cmd_t cmd;
        logic [2:0] ns;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == 20) begin
                hold_pending = 1'b1;
            end
            r = $urandom_range(0, 99);
            ns = 3'($urandom_range(0, 7));
            if (r < 50) begin
                cmd = CMD_TICK;
            end else if (r < 72) begin
                cmd = CMD_CAPTURE;
            end else if (r < 94) begin
                cmd = CMD_SET;
                if ($urandom_range(0, 99) < 60) begin
                    ns = ST_ARMED;
                end
            end else begin
                cmd = CMD_RESTART;
            end
            send_item(cmd, ns, 1'b0, '0);
        end
    endtask

    initial begin
        cnt_ticks = '0;
        start_ticks = '0;
        stop_ticks = '0;
        cur_status = ST_IDLE;
        timeout_flag = 1'b0;
        tmo_ms = 16'(TIMEOUT_RESET);
        tick_us_r = TICK_US_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle = 19;
        sink_idle = 59;
        for (int i = 0; i < DIR_N; i++) begin
            send_item(dir_rows[i].cmd, dir_rows[i].new_status, dir_rows[i].typed,
                dir_rows[i].want);
        end
        finish_phase();
        set_regs(16'hFFFF, 7'd64);
        random_items(400, 1'b0);

        finish_phase();
        src_idle = 59;
        sink_idle = 19;
        set_regs(16'd0, 7'd0);
        random_items(400, 1'b1);

        finish_phase();
        src_idle = 0;
        sink_idle = 0;
        set_regs(16'($urandom_range(0, 65535)), 7'($urandom_range(1, 64)));
        random_items(400, 1'b1);

        finish_phase();
        repeat (8) @(posedge aclk);
        $display("Checked %0d results from %0d command transfers in %0d cycles.",
            checked_count, sent_count, cycle_count);
        $display("Covered all commands, ignored writes and captures, and four register settings.");
        if (err_count == 0) begin
            $display("[capture_period_meter_top] OK");
        end else begin
            $display("%0d mismatches found.", err_count);
            $display("[capture_period_meter_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/cpm_pkg.sv
design/cpm_tracker.sv
design/cpm_scaler.sv
design/capture_period_meter_top.sv
design/cpm_checker.sv
tb/tb.sv
